// File: design/kermit_packet_deframer_macros.svh
// Assertion macros shared by the deframer modules (clk and rst must be in scope).
`ifndef KERMIT_PACKET_DEFRAMER_MACROS_SVH
`define KERMIT_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kpd_pkg.sv
// Shared types and constants for the Kermit packet deframer.
package kpd_pkg;

  // Configuration port
  localparam int unsigned KPD_ADDR_W = 3;
  localparam int unsigned KPD_DATA_W = 32;

  typedef enum logic {
    REG_START_MARK = 1'b0,
    REG_QUOTE_CHAR = 1'b1
  } reg_idx_t;

  localparam logic [7:0] START_MARK_RESET = 8'd1;
  localparam logic [7:0] QUOTE_CHAR_RESET = 8'd35;

  // Protocol constants
  localparam logic [7:0] MIN_LEN_CHAR = 8'd35;   // length char for length 3
  localparam logic [7:0] CHAR_BIAS    = 8'd32;   // printable offset (unchar)
  localparam logic [7:0] QUOTE_FLIP   = 8'd64;   // ctl() toggle bit
  localparam logic [6:0] MAX_DATA     = 7'd127;  // saturated data count

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_SEQ  = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_CHK  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_BAD       = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] start_mark;
    logic [7:0] quote_char;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] seq_num;
    logic [7:0] packet_kind;
  } result_t;

endpackage

// File: design/kpd_regs.sv
// APB-style configuration registers: start mark and quote character.
module kpd_regs
  import kpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [KPD_ADDR_W-1:0] paddr,
  input  logic [KPD_DATA_W-1:0] pwdata,
  output logic [KPD_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mark <= START_MARK_RESET;
      cfg.quote_char <= QUOTE_CHAR_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_MARK: cfg.start_mark <= pwdata[7:0];
        REG_QUOTE_CHAR: cfg.quote_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_START_MARK: prdata = {{(KPD_DATA_W-8){1'b0}}, cfg.start_mark};
      REG_QUOTE_CHAR: prdata = {{(KPD_DATA_W-8){1'b0}}, cfg.quote_char};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: design/kpd_parser.sv
// Packet parser: per-byte state update and result decode.
module kpd_parser
  import kpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [6:0] remaining, remaining_next;
  logic [7:0] sum_acc, sum_acc_next;
  logic [5:0] seq_hold, seq_hold_next;
  logic [7:0] type_hold, type_hold_next;
  logic       quote_pending, quote_pending_next;

  logic [7:0] len_cnt;
  logic [7:0] seq_char;
  logic [7:0] sum_add;
  logic [6:0] rem_dec;
  logic       is_quote;
  logic [5:0] chk_low;
  logic [7:0] chk;

  // Shared arithmetic
  assign len_cnt  = rx_byte - MIN_LEN_CHAR;
  assign seq_char = rx_byte - CHAR_BIAS;
  assign sum_add  = sum_acc + rx_byte;
  assign rem_dec  = remaining - 7'd1;
  assign is_quote = (rx_byte == cfg.quote_char);
  // type 1 check: fold top two bits into the low six, make printable
  assign chk_low  = sum_acc[5:0] + {4'd0, sum_acc[7:6]};
  assign chk      = {2'b00, chk_low} + CHAR_BIAS;

  // Next state
  always_comb begin
    phase_next         = phase;
    remaining_next     = remaining;
    sum_acc_next       = sum_acc;
    seq_hold_next      = seq_hold;
    type_hold_next     = type_hold;
    quote_pending_next = quote_pending;
    case (phase)
      PH_LEN: begin
        if (rx_byte < MIN_LEN_CHAR) begin
          phase_next = PH_HUNT;
        end else begin
          remaining_next     = len_cnt[7] ? MAX_DATA : len_cnt[6:0];
          sum_acc_next       = rx_byte;
          quote_pending_next = 1'b0;
          phase_next         = PH_SEQ;
        end
      end
      PH_SEQ: begin
        seq_hold_next = seq_char[5:0];
        sum_acc_next  = sum_add;
        phase_next    = PH_TYPE;
      end
      PH_TYPE: begin
        type_hold_next = rx_byte;
        sum_acc_next   = sum_add;
        phase_next     = (remaining != 7'd0) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        sum_acc_next   = sum_add;
        remaining_next = rem_dec;
        if (quote_pending) begin
          quote_pending_next = 1'b0;
        end else if (is_quote) begin
          quote_pending_next = 1'b1;
        end
        // last data char: a dangling quote is dropped
        if (rem_dec == 7'd0) begin
          quote_pending_next = 1'b0;
          phase_next         = PH_CHK;
        end
      end
      PH_CHK: begin
        phase_next         = PH_HUNT;
        quote_pending_next = 1'b0;
      end
      default: begin
        phase_next = (rx_byte == cfg.start_mark) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  // Result decode
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_DATA;
    res.data_byte   = 8'd0;
    res.seq_num     = seq_hold;
    res.packet_kind = type_hold;
    case (phase)
      PH_LEN: begin
        if (rx_byte < MIN_LEN_CHAR) begin
          res_valid       = 1'b1;
          res.kind        = KIND_MALFORMED;
          res.seq_num     = 6'd0;
          res.packet_kind = 8'd0;
        end
      end
      PH_DATA: begin
        if (quote_pending) begin
          res_valid     = 1'b1;
          res.data_byte = is_quote ? rx_byte : (rx_byte ^ QUOTE_FLIP);
        end else if (!is_quote) begin
          res_valid     = 1'b1;
          res.data_byte = rx_byte;
        end
      end
      PH_CHK: begin
        res_valid = 1'b1;
        res.kind  = (rx_byte == chk) ? KIND_GOOD : KIND_BAD;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      remaining     <= 7'd0;
      sum_acc       <= 8'd0;
      seq_hold      <= 6'd0;
      type_hold     <= 8'd0;
      quote_pending <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      remaining     <= remaining_next;
      sum_acc       <= sum_acc_next;
      seq_hold      <= seq_hold_next;
      type_hold     <= type_hold_next;
      quote_pending <= quote_pending_next;
    end
  end

`include "kermit_packet_deframer_macros.svh"

  `KPD_ASSERT_NOW(a_data_count, phase == PH_DATA, remaining != 7'd0, "data phase with zero count")
  `KPD_ASSERT_NEXT(a_chk_to_hunt, accept && phase == PH_CHK, phase == PH_HUNT, "no hunt after checksum")
  `KPD_ASSERT_NEXT(a_last_data, accept && phase == PH_DATA && remaining == 7'd1, phase == PH_CHK && !quote_pending, "last data char mishandled")

endmodule

// File: design/kpd_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
module kpd_out_buf
  import kpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

`include "kermit_packet_deframer_macros.svh"

  `KPD_ASSERT_NOW(a_no_overflow, push, !full, "push into full buffer")
  `KPD_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "fill count out of range")
  `KPD_ASSERT_NEXT(a_push_only, push && !pop, count == $past(count) + 2'd1, "push not counted")

endmodule

// File: design/kermit_packet_deframer.sv
// Kermit packet deframer: hunts for the start mark, parses length, sequence
// and type, emits unquoted data bytes and reports the type 1 checksum result
// (good, bad, or malformed length). The parser state updates at acceptance
// and any result lands in a two-entry output buffer the same edge, so a byte
// can be accepted every cycle as long as the output side keeps draining.
// in_ready drops only while both buffer entries hold undelivered results.
// Data bytes reported before a bad checksum must be discarded downstream.
// Configuration (start mark at address 0, quote character at address 4) is
// to be written over the APB port only while the block is idle; the block
// itself does not enforce this.
module kermit_packet_deframer
  import kpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [KPD_ADDR_W-1:0] paddr,
  input  logic [KPD_DATA_W-1:0] pwdata,
  output logic [KPD_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic [5:0]            seq_num,
  output logic [7:0]            packet_kind
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_data;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  kpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  kpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result fields
  assign kind        = out_data.kind;
  assign data_byte   = out_data.data_byte;
  assign seq_num     = out_data.seq_num;
  assign packet_kind = out_data.packet_kind;

endmodule

// File: verif/tb.sv
// Testbench for the Kermit packet deframer: directed and random frames checked by a byte predictor.
module tb;
  import kpd_pkg::*;

  localparam logic [7:0] CHK_MASK = 8'h3F;   // type 1 check keeps six bits

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [KPD_ADDR_W-1:0] paddr = '0;
  logic [KPD_DATA_W-1:0] pwdata = '0;
  logic [KPD_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            kind;
  logic [7:0]            data_byte;
  logic [5:0]            seq_num;
  logic [7:0]            packet_kind;

  kermit_packet_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .seq_num    (seq_num),
    .packet_kind(packet_kind)
  );

  always #10 clk = ~clk;

  // Predictor copy of the parser state and registers
  phase_t     rx_phase = PH_HUNT;
  logic [6:0] data_left = '0;
  logic [7:0] run_sum = '0;
  logic [5:0] cur_seq = '0;
  logic [7:0] cur_type = '0;
  logic       quote_open = 1'b0;
  logic [7:0] cfg_start = START_MARK_RESET;
  logic [7:0] cfg_quote = QUOTE_CHAR_RESET;

  result_t    deframed_q[$];   // decoded events still owed by the block
  logic [7:0] frame_body[$];   // raw data field of the frame being built
  int         mismatches = 0;
  int         rx_count = 0;    // bytes that the parser does not ignore
  bit         fast_in = 1'b0;
  bit         fast_out = 1'b0;

  function automatic logic [7:0] type1_check(input logic [7:0] s);
    logic [7:0] folded;
    folded = s + {6'b0, s[7:6]};
    return (folded & CHK_MASK) + CHAR_BIAS;
  endfunction

  // Advance the parser copy by one byte and queue what it reports
  task automatic deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] cnt;
    logic [7:0] unch;
    r = '0;
    case (rx_phase)
      PH_LEN: begin
        if (b < MIN_LEN_CHAR) begin
          rx_phase = PH_HUNT;
          r.kind = KIND_MALFORMED;
          deframed_q.push_back(r);
        end else begin
          cnt = b - MIN_LEN_CHAR;
          data_left = (cnt > {1'b0, MAX_DATA}) ? MAX_DATA : cnt[6:0];
          run_sum = b;
          quote_open = 1'b0;
          rx_phase = PH_SEQ;
        end
      end
      PH_SEQ: begin
        unch = b - CHAR_BIAS;
        cur_seq = unch[5:0];
        run_sum = run_sum + b;
        rx_phase = PH_TYPE;
      end
      PH_TYPE: begin
        cur_type = b;
        run_sum = run_sum + b;
        rx_phase = (data_left != 0) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        run_sum = run_sum + b;
        data_left = data_left - 7'd1;
        r.kind = KIND_DATA;
        r.seq_num = cur_seq;
        r.packet_kind = cur_type;
        if (quote_open) begin
          r.data_byte = (b == cfg_quote) ? b : (b ^ QUOTE_FLIP);
          quote_open = 1'b0;
          deframed_q.push_back(r);
        end else if (b == cfg_quote) begin
          quote_open = 1'b1;
        end else begin
          r.data_byte = b;
          deframed_q.push_back(r);
        end
        if (data_left == 0) begin
          quote_open = 1'b0;
          rx_phase = PH_CHK;
        end
      end
      PH_CHK: begin
        r.kind = (b == type1_check(run_sum)) ? KIND_GOOD : KIND_BAD;
        r.seq_num = cur_seq;
        r.packet_kind = cur_type;
        quote_open = 1'b0;
        rx_phase = PH_HUNT;
        deframed_q.push_back(r);
      end
      default: begin
        rx_phase = (b == cfg_start) ? PH_LEN : PH_HUNT;
      end
    endcase
  endtask

  // One input request, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (rx_phase != PH_HUNT || b == cfg_start) rx_count++;
    deframe_byte(b);
  endtask

  // Start mark, header, frame_body, then a good or corrupted check byte
  task automatic send_frame(input logic [7:0] seq_c, input logic [7:0] typ_c,
                            input logic [7:0] len_c, input bit good);
    logic [7:0] s;
    logic [7:0] chk;
    s = len_c + seq_c + typ_c;
    foreach (frame_body[i]) s = s + frame_body[i];
    chk = type1_check(s);
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(cfg_start);
    send_byte(len_c);
    send_byte(seq_c);
    send_byte(typ_c);
    foreach (frame_body[i]) send_byte(frame_body[i]);
    send_byte(chk);
  endtask

  // Hold off input until every queued event has been delivered
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (deframed_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle before the next request
    @(posedge clk);
    if (idx == REG_START_MARK) cfg_start = val;
    else cfg_quote = val;
  endtask

  // Empty data field with the reset register values
  task automatic test_empty_frame();
    frame_body.delete();
    send_frame(CHAR_BIAS, 8'h59, MIN_LEN_CHAR, 1'b1);
  endtask

  // Length characters below the minimum, including zero
  task automatic test_short_length();
    send_byte(cfg_start);
    send_byte(MIN_LEN_CHAR - 8'd1);
    send_byte(cfg_start);
    send_byte(8'h00);
  endtask

  // Quoted control char, quoted quote char, byte extremes, bad check
  task automatic test_quoting();
    frame_body.delete();
    frame_body.push_back(cfg_quote);
    frame_body.push_back(8'h41);
    frame_body.push_back(cfg_quote);
    frame_body.push_back(cfg_quote);
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h00);
    send_frame(8'hFF, 8'h00, MIN_LEN_CHAR + 8'd6, 1'b0);
  endtask

  // Quote char as the last data char is dropped
  task automatic test_dangling_quote();
    frame_body.delete();
    frame_body.push_back(cfg_quote);
    send_frame(8'h5F, 8'hFF, MIN_LEN_CHAR + 8'd1, 1'b1);
  endtask

  task automatic test_config_setting(input logic [7:0] sm, input logic [7:0] qc);
    settle();
    write_reg(REG_START_MARK, sm);
    write_reg(REG_QUOTE_CHAR, qc);
  endtask

  // Mostly well-formed frames with random content, plus malformed and noise
  task automatic test_random_traffic(input int n_items);
    int         first;
    int         pick;
    int         nslots;
    bit         long_frame;
    logic [7:0] len_c;
    logic [7:0] b;
    first = rx_count;
    while (rx_count - first < n_items) begin
      if ($urandom_range(0, 19) == 0) fast_in = ~fast_in;
      if ($urandom_range(0, 19) == 0) fast_out = ~fast_out;
      if ($urandom_range(0, 49) == 0) settle();
      // finish any broken frame with random bytes
      while (rx_phase != PH_HUNT) send_byte(8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        long_frame = ($urandom_range(0, 99) < 2);
        if (long_frame) nslots = MAX_DATA;
        else if ($urandom_range(0, 1) == 0) nslots = $urandom_range(0, 4);
        else nslots = $urandom_range(5, 14);
        frame_body.delete();
        while (frame_body.size() < nslots) begin
          pick = $urandom_range(0, 99);
          if (pick < 20 && frame_body.size() + 2 <= nslots) begin
            frame_body.push_back(cfg_quote);
            frame_body.push_back(($urandom_range(0, 9) == 0) ? cfg_quote : 8'($urandom));
          end else if (pick < 25) begin
            frame_body.push_back(cfg_start);
          end else begin
            frame_body.push_back(8'($urandom));
          end
        end
        if (nslots > 0 && $urandom_range(0, 9) == 0) frame_body[nslots-1] = cfg_quote;
        len_c = long_frame ? 8'($urandom_range(162, 255)) : 8'(nslots) + MIN_LEN_CHAR;
        send_frame(8'($urandom), 8'($urandom), len_c, $urandom_range(0, 99) < 85);
      end else if (pick < 85) begin
        send_byte(cfg_start);
        send_byte(8'($urandom_range(0, MIN_LEN_CHAR - 1)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if (b == cfg_start) b = ~b;
          send_byte(b);
        end
      end
    end
  endtask

  // Output side: random stall before each request, then compare
  initial begin : result_check
    int      stall;
    result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = fast_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (deframed_q.size() == 0) begin
        $error("result with nothing expected: kind %0d data %0d", kind, data_byte);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        if (kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatches++;
        end
        if (data_byte != want.data_byte) begin
          $error("data_byte: expected %0d, got %0d", want.data_byte, data_byte);
          mismatches++;
        end
        if (seq_num != want.seq_num) begin
          $error("seq_num: expected %0d, got %0d", want.seq_num, seq_num);
          mismatches++;
        end
        if (packet_kind != want.packet_kind) begin
          $error("packet_kind: expected %0d, got %0d", want.packet_kind, packet_kind);
          mismatches++;
        end
      end
    end
  end

  initial begin : timeout
    #10_000_000;
    $display("kermit_packet_deframer: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_frame();
    test_short_length();
    test_quoting();
    test_dangling_quote();
    test_random_traffic(600);
    test_config_setting(8'h00, 8'hFF);
    test_random_traffic(300);
    test_config_setting(8'hFF, 8'h00);
    test_random_traffic(300);
    test_config_setting(8'($urandom), 8'($urandom));
    test_random_traffic(300);
    test_config_setting(START_MARK_RESET, QUOTE_CHAR_RESET);
    test_random_traffic(300);
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("kermit_packet_deframer: match");
    end else begin
      $display("kermit_packet_deframer: mismatch");
    end
    $finish;
  end

endmodule
